FILE: sv/idalloc_pkg.sv
package idalloc_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int HANDLE_BITS_DEF = 32;

  localparam logic [2:0] KIND_ALLOC   = 3'd0;
  localparam logic [2:0] KIND_CLAIM   = 3'd1;
  localparam logic [2:0] KIND_RELEASE = 3'd2;
  localparam logic [2:0] KIND_LOOKUP  = 3'd3;
  localparam logic [2:0] KIND_FIRST   = 3'd4;
  localparam logic [2:0] KIND_NEXT    = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] req_id;
    logic [31:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic [31:0] handle_out;
    logic [1:0]  status;
    logic [8:0]  live_count;
  } out_item_t;

endpackage

FILE: sv/idalloc_ram.sv
module idalloc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/id_allocator_with_free_stack.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_item  (kind, req_id, handle)
// out       output     out_valid / out_stall out_item (result_id, handle_out, status, live_count)
// cfg       input      cfg_wr_en            cfg_wr_data (id_offset)
//
// Each beat passes through dispatch, its work states and the finish state, and no new beat
// is taken before the sequencer is back in idle. An allocate that pops the stack adds a
// stack read state. A claim inside the table reads and compares each stack entry searched
// and reads then writes each entry shifted down; a claim past the end spends a push step
// on each skipped slot; first and next scans read and compare each slot visited. The single
// read port of each RAM sets this. Reset is synchronous; the slot table needs no clearing
// since slots at or above the table length are never read. A stalled result waits in the
// output register while the next beat may already be accepted.
module id_allocator_with_free_stack #(
  parameter int CAPACITY    = idalloc_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = idalloc_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  idalloc_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output idalloc_pkg::out_item_t out_item,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data
);
  import idalloc_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int HW    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DISP   = 15'b000000000000010,
    S_PUSH   = 15'b000000000000100,
    S_CL_RD  = 15'b000000000001000,
    S_SR_RD  = 15'b000000000010000,
    S_SR_CMP = 15'b000000000100000,
    S_SH_RD  = 15'b000000001000000,
    S_SH_WR  = 15'b000000010000000,
    S_AL     = 15'b000000100000000,
    S_AL_RD  = 15'b000001000000000,
    S_RL_CHK = 15'b000010000000000,
    S_LK_CHK = 15'b000100000000000,
    S_SC_RD  = 15'b001000000000000,
    S_SC_CMP = 15'b010000000000000,
    S_FIN    = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  logic [31:0]      id_offset;
  logic [2:0]       kind;
  logic [31:0]      req;
  logic [HW-1:0]    h;
  logic [31:0]      u, u_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] fdepth, fdepth_next;
  logic [CNT_W-1:0] tlen, tlen_next;
  logic [CNT_W-1:0] occ, occ_next;
  logic [31:0]      res_id, res_id_next;
  logic [HW-1:0]    res_h, res_h_next;
  logic [1:0]       res_st, res_st_next;

  logic             slot_we, stk_we;
  logic [IDX_W-1:0] slot_waddr, slot_raddr, stk_waddr, stk_raddr;
  logic [HW-1:0]    slot_wdata, slot_rdata;
  logic [IDX_W-1:0] stk_wdata, stk_rdata;

  logic [IDX_W-1:0] u_idx, k_idx;
  logic             out_load;

  assign u_idx = u[IDX_W-1:0];
  assign k_idx = k[IDX_W-1:0];
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  idalloc_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  idalloc_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_comb begin
    state_next  = state;
    u_next      = u;
    k_next      = k;
    fdepth_next = fdepth;
    tlen_next   = tlen;
    occ_next    = occ;
    res_id_next = res_id;
    res_h_next  = res_h;
    res_st_next = res_st;
    slot_we     = 1'b0;
    slot_waddr  = '0;
    slot_wdata  = '0;
    slot_raddr  = '0;
    stk_we      = 1'b0;
    stk_waddr   = '0;
    stk_wdata   = '0;
    stk_raddr   = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          u_next     = in_item.req_id - id_offset;
          state_next = S_DISP;
        end
      end

      S_DISP: begin
        res_id_next = '0;
        res_h_next  = '0;
        res_st_next = ST_NONE;
        state_next  = S_FIN;
        if (kind == KIND_ALLOC || kind == KIND_CLAIM) begin
          if (h == '0) begin
            res_st_next = ST_NULL;
          end else if (kind == KIND_ALLOC) begin
            state_next = S_AL;
          end else if (u >= 32'(CAPACITY)) begin
            res_st_next = ST_FULL;
          end else if (CNT_W'(u) >= tlen) begin
            k_next     = CNT_W'(u);
            state_next = S_PUSH;
          end else begin
            slot_raddr = u_idx;
            state_next = S_CL_RD;
          end
        end else if (kind == KIND_RELEASE) begin
          if (u < 32'(tlen)) begin
            slot_raddr = u_idx;
            state_next = S_RL_CHK;
          end
        end else if (kind == KIND_LOOKUP) begin
          res_id_next = req;
          if (u < 32'(tlen)) begin
            slot_raddr = u_idx;
            state_next = S_LK_CHK;
          end
        end else if (kind == KIND_FIRST) begin
          k_next     = '0;
          state_next = S_SC_RD;
        end else if (kind == KIND_NEXT) begin
          if ((u + 32'd1) >= 32'(tlen)) begin
            res_id_next = u + 32'd1 + id_offset;
          end else begin
            k_next     = CNT_W'(u + 32'd1);
            state_next = S_SC_RD;
          end
        end
      end

      // Skipped slots go on the stack from the top down so the old end sits on top.
      S_PUSH: begin
        if (k > tlen) begin
          k_next     = k - 1'b1;
          slot_we    = 1'b1;
          slot_waddr = IDX_W'(k - 1'b1);
          slot_wdata = '0;
          if (fdepth < CAP_C) begin
            stk_we      = 1'b1;
            stk_waddr   = fdepth[IDX_W-1:0];
            stk_wdata   = IDX_W'(k - 1'b1);
            fdepth_next = fdepth + 1'b1;
          end
        end else begin
          slot_we     = 1'b1;
          slot_waddr  = u_idx;
          slot_wdata  = h;
          tlen_next   = CNT_W'(u) + 1'b1;
          occ_next    = occ + 1'b1;
          res_id_next = req;
          res_h_next  = h;
          res_st_next = ST_OK;
          state_next  = S_FIN;
        end
      end

      S_CL_RD: begin
        k_next     = '0;
        state_next = (slot_rdata == '0) ? S_SR_RD : S_AL;
      end

      S_SR_RD: begin
        if (k < fdepth) begin
          stk_raddr  = k_idx;
          state_next = S_SR_CMP;
        end else begin
          state_next = S_AL;
        end
      end

      S_SR_CMP: begin
        if (stk_rdata == u_idx) begin
          state_next = S_SH_RD;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_SR_RD;
        end
      end

      // Close the gap left by the claimed entry, one entry per read and write pair.
      S_SH_RD: begin
        if ((k + 1'b1) < fdepth) begin
          stk_raddr  = IDX_W'(k + 1'b1);
          state_next = S_SH_WR;
        end else begin
          fdepth_next = fdepth - 1'b1;
          slot_we     = 1'b1;
          slot_waddr  = u_idx;
          slot_wdata  = h;
          occ_next    = occ + 1'b1;
          res_id_next = u + id_offset;
          res_h_next  = h;
          res_st_next = ST_OK;
          state_next  = S_FIN;
        end
      end

      S_SH_WR: begin
        stk_we     = 1'b1;
        stk_waddr  = k_idx;
        stk_wdata  = stk_rdata;
        k_next     = k + 1'b1;
        state_next = S_SH_RD;
      end

      S_AL: begin
        state_next = S_FIN;
        if (fdepth != '0) begin
          stk_raddr   = IDX_W'(fdepth - 1'b1);
          fdepth_next = fdepth - 1'b1;
          state_next  = S_AL_RD;
        end else if (tlen < CAP_C) begin
          slot_we     = 1'b1;
          slot_waddr  = tlen[IDX_W-1:0];
          slot_wdata  = h;
          tlen_next   = tlen + 1'b1;
          occ_next    = occ + 1'b1;
          res_id_next = 32'(tlen) + id_offset;
          res_h_next  = h;
          res_st_next = ST_OK;
        end else begin
          res_id_next = '0;
          res_h_next  = '0;
          res_st_next = ST_FULL;
        end
      end

      S_AL_RD: begin
        slot_we     = 1'b1;
        slot_waddr  = stk_rdata;
        slot_wdata  = h;
        occ_next    = occ + 1'b1;
        res_id_next = 32'(stk_rdata) + id_offset;
        res_h_next  = h;
        res_st_next = ST_OK;
        state_next  = S_FIN;
      end

      S_RL_CHK: begin
        state_next = S_FIN;
        if (slot_rdata != '0) begin
          slot_we    = 1'b1;
          slot_waddr = u_idx;
          slot_wdata = '0;
          if (fdepth < CAP_C) begin
            stk_we      = 1'b1;
            stk_waddr   = fdepth[IDX_W-1:0];
            stk_wdata   = u_idx;
            fdepth_next = fdepth + 1'b1;
          end
          occ_next    = occ - 1'b1;
          res_id_next = req;
          res_h_next  = slot_rdata;
          res_st_next = ST_OK;
        end
      end

      S_LK_CHK: begin
        res_h_next  = slot_rdata;
        res_st_next = (slot_rdata != '0) ? ST_OK : ST_NONE;
        state_next  = S_FIN;
      end

      S_SC_RD: begin
        if (k < tlen) begin
          slot_raddr = k_idx;
          state_next = S_SC_CMP;
        end else begin
          res_id_next = (kind == KIND_NEXT) ? 32'(tlen) + id_offset : '0;
          res_h_next  = '0;
          res_st_next = ST_NONE;
          state_next  = S_FIN;
        end
      end

      S_SC_CMP: begin
        if (slot_rdata != '0) begin
          res_id_next = 32'(k) + id_offset;
          res_h_next  = slot_rdata;
          res_st_next = ST_OK;
          state_next  = S_FIN;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_SC_RD;
        end
      end

      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      id_offset <= '0;
      fdepth    <= '0;
      tlen      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      fdepth <= fdepth_next;
      tlen   <= tlen_next;
      occ    <= occ_next;
      if (cfg_wr_en) begin
        id_offset <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      kind <= in_item.kind;
      req  <= in_item.req_id;
      h    <= in_item.handle[HW-1:0];
    end
    u      <= u_next;
    k      <= k_next;
    res_id <= res_id_next;
    res_h  <= res_h_next;
    res_st <= res_st_next;
    if (out_load) begin
      out_item.result_id  <= res_id;
      out_item.handle_out <= 32'(res_h);
      out_item.status     <= res_st;
      out_item.live_count <= 9'(occ);
    end
  end

endmodule

FILE: sv/idalloc_chk.sv
module idalloc_chk (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input idalloc_pkg::out_item_t out_item
);
  import idalloc_pkg::*;

  // An accepted beat keeps the sequencer busy, so the input is not taken again right after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a beat");

  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_NULL |->
      out_item.result_id == 32'd0 && out_item.handle_out == 32'd0)
    else $error("null handle result carries data");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_FULL |->
      out_item.result_id == 32'd0 && out_item.handle_out == 32'd0)
    else $error("full table result carries data");

  a_ok_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_OK |-> out_item.handle_out != 32'd0)
    else $error("successful result with empty handle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind id_allocator_with_free_stack idalloc_chk u_idalloc_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
